/* sv/hfve_pkg.sv */
// Package for the hot filter with vote eviction.
// Holds the channel payload types, register indexes and hash constants.
// No dependencies.
package hfve_pkg;

	typedef struct packed {
		logic               op;
		logic signed [31:0] key;
		logic [15:0]        weight;
	} in_t;

	typedef struct packed {
		logic               spill_valid;
		logic signed [31:0] spill_key;
		logic [31:0]        spill_count;
		logic [40:0]        rank_sum;
	} out_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_RANK   = 1'b1;

	localparam logic CFG_CAPACITY  = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int          MIX_S0 = 30;
	localparam int          MIX_S1 = 27;
	localparam int          MIX_S2 = 31;

	localparam logic [40:0] RANK_MAX = {41{1'b1}};
	localparam logic [31:0] VOTE_MAX = 32'hffff_ffff;

endpackage

/* sv/hot_filter_vote_eviction_top.sv */
// Hot filter with vote eviction: hashed, bucketed frequency table in front of
// a quantile sketch. Handles one transaction at a time. After reset a clearing
// pass zeroes fill levels and votes of every bucket; inputs stall then.
// An insert first computes the bucket hash (mixing on the shared 32x32
// multiplier, the remainder by reciprocal multiplication, then the bucket is
// handed over), then scans the stored ways of the bucket and does the
// bookkeeping; the entry RAM read port sets the per-way cost. A rank query
// walks every bucket and reads every stored entry.
// The block returns to idle between transactions. A result waits in an output register
// while the next transaction is taken. Depends on hfve_pkg, hfve_ram and hfve_hash.
module hot_filter_vote_eviction_top #(
	parameter int NUM_BUCKETS = 64,
	parameter int WAYS        = 8,
	parameter int COUNT_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hfve_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output hfve_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);
	import hfve_pkg::*;

	localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int FW    = $clog2(WAYS + 1);
	localparam int CW    = COUNT_BITS;
	localparam int EDEP  = NUM_BUCKETS * WAYS;
	localparam int EAW   = (EDEP > 1) ? $clog2(EDEP) : 1;
	localparam int SW    = ((CW > 41) ? CW : 41) + 1;
	localparam int MWID  = FW + 32;
	localparam int EWID  = 32 + CW;

	typedef enum logic [13:0] {
		S_CLEAR  = 14'b00000000000001,
		S_IDLE   = 14'b00000000000010,
		S_HASH   = 14'b00000000000100,
		S_MRD    = 14'b00000000001000,
		S_MWAIT  = 14'b00000000010000,
		S_ERD    = 14'b00000000100000,
		S_ECHK   = 14'b00000001000000,
		S_CMP    = 14'b00000010000000,
		S_DECIDE = 14'b00000100000000,
		S_NEXT   = 14'b00001000000000,
		S_OUT    = 14'b00010000000000,
		S_SPARE0 = 14'b00100000000000,
		S_SPARE1 = 14'b01000000000000,
		S_SPARE2 = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [3:0]  cap_q;
	logic [15:0] thr_q;

	logic               op_q;
	logic [31:0]        key_q;
	logic [15:0]        weight_q;
	logic [BW-1:0]      bkt_q;
	logic [FW-1:0]      fill_q, way_q, hit_way_q, min_way_q;
	logic [31:0]        vote_q, min_key_q;
	logic               hit_q, minv_q;
	logic [CW-1:0]      hit_cnt_q, min_q;
	logic [40:0]        sum_q;
	logic [47:0]        prod_q;
	out_t               res_q, out_q;
	logic               out_valid_q;

	// hash unit
	logic          h_start, h_done;
	logic [BW-1:0] h_bucket;

	// memories
	logic            mwe, ewe;
	logic [BW-1:0]   mwaddr;
	logic [MWID-1:0] mwdata, mrdata;
	logic [EAW-1:0]  ewaddr, eraddr;
	logic [EWID-1:0] ewdata, erdata;

	logic [FW-1:0]   mr_fill;
	logic [31:0]     mr_vote, er_key;
	logic [CW-1:0]   er_cnt;
	logic [CW-1:0]   wcl, hit_sum;
	logic [CW:0]     hs_wide;
	logic [CW+15:0]  w_wide;
	logic [63:0]     min64;
	logic [31:0]     vote_inc;
	logic [4:0]      cap_eff;
	logic            way_free, replace, in_acc, out_acc, out_load, last_way;
	logic [SW-1:0]   rs_wide;
	logic [40:0]     sum_n;
	out_t            dec_res;

	function automatic logic [EAW-1:0] eaddr(input logic [BW-1:0] b, input logic [FW-1:0] w);
		return EAW'(b) * EAW'(WAYS) + EAW'(w);
	endfunction

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign h_start  = in_acc && (in_data.op == OP_INSERT);

	hfve_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.key    (in_data.key),
		.done   (h_done),
		.bucket (h_bucket)
	);

	hfve_ram #(.WIDTH(MWID), .DEPTH(NUM_BUCKETS)) u_meta (
		.clk   (clk),
		.we    (mwe),
		.waddr (mwaddr),
		.wdata (mwdata),
		.raddr (bkt_q),
		.rdata (mrdata)
	);

	hfve_ram #(.WIDTH(EWID), .DEPTH(EDEP)) u_entry (
		.clk   (clk),
		.we    (ewe),
		.waddr (ewaddr),
		.wdata (ewdata),
		.raddr (eraddr),
		.rdata (erdata)
	);

	always_comb begin
		mr_fill  = mrdata[MWID-1:32];
		mr_vote  = mrdata[31:0];
		er_key   = erdata[EWID-1:CW];
		er_cnt   = erdata[CW-1:0];
		eraddr   = eaddr(bkt_q, way_q);
		last_way = (way_q + FW'(1)) == fill_q;

		w_wide = {{CW{1'b0}}, weight_q};
		wcl    = (w_wide > {{16{1'b0}}, {CW{1'b1}}}) ? {CW{1'b1}} : w_wide[CW-1:0];
		hs_wide = {1'b0, hit_cnt_q} + {1'b0, wcl};
		hit_sum = hs_wide[CW] ? {CW{1'b1}} : hs_wide[CW-1:0];

		min64    = 64'(min_q);
		vote_inc = (vote_q == VOTE_MAX) ? VOTE_MAX : vote_q + 32'd1;
		cap_eff  = ({1'b0, cap_q} > 5'(WAYS)) ? 5'(WAYS) : {1'b0, cap_q};
		way_free = 5'(fill_q) < cap_eff;
		// floor(vote/min) >= thr  <=>  vote >= thr*min
		replace  = (min64[63:32] == 32'd0) ? ({16'd0, vote_inc} >= prod_q) : (thr_q == 16'd0);

		rs_wide = SW'(sum_q) + SW'(er_cnt);
		sum_n   = (rs_wide > SW'(RANK_MAX)) ? RANK_MAX : rs_wide[40:0];

		dec_res = '0;
		if (!hit_q && !way_free) begin
			dec_res.spill_valid = 1'b1;
			if (fill_q != '0 && replace) begin
				dec_res.spill_key   = min_key_q;
				dec_res.spill_count = (min64[63:32] != 32'd0) ? 32'hffff_ffff : min64[31:0];
			end else begin
				dec_res.spill_key   = key_q;
				dec_res.spill_count = {16'd0, weight_q};
			end
		end

		mwe    = 1'b0;
		mwaddr = bkt_q;
		mwdata = '0;
		ewe    = 1'b0;
		ewaddr = eaddr(bkt_q, hit_way_q);
		ewdata = {key_q, hit_sum};

		case (state_q)
			S_CLEAR: begin
				mwe = 1'b1;
			end
			S_DECIDE: begin
				if (hit_q) begin
					ewe = 1'b1;
				end else if (way_free) begin
					ewe    = 1'b1;
					ewaddr = eaddr(bkt_q, fill_q);
					ewdata = {key_q, wcl};
					mwe    = 1'b1;
					mwdata = {fill_q + FW'(1), vote_q};
				end else if (fill_q != '0 && replace) begin
					ewe    = 1'b1;
					ewaddr = eaddr(bkt_q, min_way_q);
					ewdata = {key_q, wcl};
					mwe    = 1'b1;
					mwdata = {fill_q, 32'd0};
				end else begin
					mwe    = 1'b1;
					mwdata = {fill_q, vote_inc};
				end
			end
			default: begin
			end
		endcase
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 4'd8;
			thr_q <= 16'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAPACITY:  cap_q <= cfg_data[3:0];
				CFG_THRESHOLD: thr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			bkt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (bkt_q == BW'(NUM_BUCKETS - 1)) begin
						bkt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						bkt_q <= bkt_q + BW'(1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						bkt_q   <= '0;
						state_q <= (in_data.op == OP_RANK) ? S_MRD : S_HASH;
					end
				end
				S_HASH: begin
					if (h_done) begin
						bkt_q   <= h_bucket;
						state_q <= S_MRD;
					end
				end
				S_MRD:  state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mr_fill == '0) begin
						state_q <= (op_q == OP_RANK) ? S_NEXT : S_CMP;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_ERD:  state_q <= S_ECHK;
				S_ECHK: begin
					if (op_q == OP_INSERT && er_key == key_q) begin
						state_q <= S_CMP;
					end else if (last_way) begin
						state_q <= (op_q == OP_RANK) ? S_NEXT : S_CMP;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_CMP:    state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_OUT;
				S_NEXT: begin
					if (bkt_q == BW'(NUM_BUCKETS - 1)) begin
						state_q <= S_OUT;
					end else begin
						bkt_q   <= bkt_q + BW'(1);
						state_q <= S_MRD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				op_q     <= in_data.op;
				key_q    <= in_data.key;
				weight_q <= in_data.weight;
				sum_q    <= '0;
			end
			S_MWAIT: begin
				fill_q <= mr_fill;
				vote_q <= mr_vote;
				way_q  <= '0;
				hit_q  <= 1'b0;
				minv_q <= 1'b0;
			end
			S_ECHK: begin
				way_q <= way_q + FW'(1);
				if (op_q == OP_RANK) begin
					if ($signed(er_key) <= $signed(key_q)) begin
						sum_q <= sum_n;
					end
				end else if (er_key == key_q) begin
					hit_q     <= 1'b1;
					hit_way_q <= way_q;
					hit_cnt_q <= er_cnt;
				end else if (!minv_q || er_cnt < min_q) begin
					// keep the first entry with the least count
					minv_q    <= 1'b1;
					min_q     <= er_cnt;
					min_way_q <= way_q;
					min_key_q <= er_key;
				end
			end
			S_CMP: begin
				prod_q <= thr_q * min64[31:0];
			end
			S_DECIDE: begin
				res_q <= dec_res;
			end
			S_NEXT: begin
				if (bkt_q == BW'(NUM_BUCKETS - 1)) begin
					res_q <= {1'b0, 32'd0, 32'd0, sum_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_no_entry_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !ewe) else $error("entry write during clearing pass");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE)) else $error("block idle after accepting a transaction");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mwe |-> (mwdata[MWID-1:32] <= FW'(WAYS))) else $error("fill level above way count");
	a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		h_done |-> (state_q == S_HASH)) else $error("hash result outside hash wait");
`endif
endmodule

/* sv/hfve_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hfve_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/hfve_hash.sv */
// Bucket hash: splitmix64 finalizer on the sign-extended key, then modulo
// the bucket count by reciprocal multiplication, 16 bits of the mixed value at a time.
// One shared 32x32 multiplier. Depends on hfve_pkg.
module hfve_hash #(
	parameter int NUM_BUCKETS = 64
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  logic [31:0]                                      key,
	output logic                                             done,
	output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);
	import hfve_pkg::*;

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	// floor((2^32-1)/N): the quotient estimate comes out low by at most one
	localparam logic [31:0] RECIP = 32'(64'hffff_ffff / 64'(NUM_BUCKETS));

	logic        mix_q, mod_q, phase_q, round_q, done_q;
	logic [1:0]  part_q, cnt_q;
	logic [63:0] x_q, acc_q, prod_q;
	logic [BW-1:0] r_q;

	logic [63:0]    sx, cst, acc_n;
	logic [31:0]    mul_a, mul_b;
	logic [BW+15:0] rv;
	logic [BW+16:0] qn, rr, rn;

	always_comb begin
		sx    = {{32{key[31]}}, key};
		cst   = round_q ? MIX_C2 : MIX_C1;
		rv    = {r_q, x_q[63:48]};
		mul_a = mod_q ? 32'(rv) : ((part_q == 2'd2) ? x_q[63:32] : x_q[31:0]);
		mul_b = mod_q ? RECIP : ((part_q == 2'd1) ? cst[63:32] : cst[31:0]);
		acc_n = (part_q == 2'd0) ? prod_q : acc_q + {prod_q[31:0], 32'b0};
		qn    = prod_q[47:32] * (BW+17)'(NUM_BUCKETS);
		rr    = {1'b0, rv} - qn;
		rn    = (rr >= (BW+17)'(NUM_BUCKETS)) ? rr - (BW+17)'(NUM_BUCKETS) : rr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q   <= 1'b0;
			mod_q   <= 1'b0;
			phase_q <= 1'b0;
			round_q <= 1'b0;
			done_q  <= 1'b0;
			part_q  <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mix_q   <= 1'b1;
				phase_q <= 1'b0;
				round_q <= 1'b0;
				part_q  <= '0;
			end else if (mix_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (part_q == 2'd2) begin
						part_q <= '0;
						if (round_q) begin
							mix_q <= 1'b0;
							mod_q <= 1'b1;
							cnt_q <= '0;
						end else begin
							round_q <= 1'b1;
						end
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
			end else if (mod_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						mod_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= sx ^ (sx >> MIX_S0);
		end else if (mix_q) begin
			if (!phase_q) begin
				prod_q <= mul_a * mul_b;
			end else begin
				acc_q <= acc_n;
				if (part_q == 2'd2) begin
					x_q <= round_q ? (acc_n ^ (acc_n >> MIX_S2)) : (acc_n ^ (acc_n >> MIX_S1));
					r_q <= '0;
				end
			end
		end else if (mod_q) begin
			if (!phase_q) begin
				prod_q <= mul_a * mul_b;
			end else begin
				// fold in the next 16 bits of the mixed value
				r_q <= rn[BW-1:0];
				x_q <= {x_q[47:0], 16'b0};
			end
		end
	end

	assign done   = done_q;
	assign bucket = r_q;
endmodule

/* tb/tb.sv */
// Testbench for hot_filter_vote_eviction_top: directed and random inserts and
// rank queries, checked against a behavioral model of the bucketed table.
// Depends on hfve_pkg and the block's RTL.
module tb;
	import hfve_pkg::*;

	localparam int NBKT      = 64;
	localparam int NWAY      = 8;
	localparam logic [63:0] CNT_MAX = 64'hffff_ffff;
	localparam int IDLE_LIMIT = 40000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	hot_filter_vote_eviction_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// table model
	logic signed [31:0] tbl_key [NBKT*NWAY];
	logic [63:0]        tbl_cnt [NBKT*NWAY];
	int unsigned        tbl_fill [NBKT];
	logic [31:0]        tbl_vote [NBKT];
	logic [3:0]         capacity_q;
	logic [15:0]        threshold_q;

	out_t               pending_results[$];
	logic signed [31:0] hot_keys[$];
	bit                 failed = 1'b0;
	bit                 quiet;
	int                 idle_cycles = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int bucket_hash(logic [31:0] k);
		logic [63:0] x;
		x = {{32{k[31]}}, k};
		x = (x ^ (x >> MIX_S0)) * MIX_C1;
		x = (x ^ (x >> MIX_S1)) * MIX_C2;
		x = x ^ (x >> MIX_S2);
		return int'(x % NBKT);
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		logic [64:0] s;
		s = a + b;
		return (s > lim) ? lim : s[63:0];
	endfunction

	function automatic out_t filter_step(in_t it);
		out_t        r;
		logic [63:0] acc;
		logic [63:0] lo;
		logic [63:0] q;
		int          b;
		int          base;
		int          fill;
		int          cap;
		int          lo_idx;
		r = '0;
		if (it.op == OP_RANK) begin
			acc = 0;
			for (int i = 0; i < NBKT; i++)
				for (int j = 0; j < tbl_fill[i] && j < NWAY; j++)
					if (tbl_key[i*NWAY+j] <= it.key)
						acc = sat_sum(acc, tbl_cnt[i*NWAY+j], {23'd0, RANK_MAX});
			r.rank_sum = acc[40:0];
			return r;
		end
		b = bucket_hash(it.key);
		base = b * NWAY;
		fill = (tbl_fill[b] > NWAY) ? NWAY : tbl_fill[b];
		cap = (capacity_q > NWAY) ? NWAY : capacity_q;
		for (int j = 0; j < fill; j++)
			if (tbl_key[base+j] == it.key) begin
				tbl_cnt[base+j] = sat_sum(tbl_cnt[base+j], {48'd0, it.weight}, CNT_MAX);
				return r;
			end
		if (fill < cap) begin
			tbl_key[base+fill] = it.key;
			tbl_cnt[base+fill] = {48'd0, it.weight};
			tbl_fill[b] = fill + 1;
			return r;
		end
		if (tbl_vote[b] != VOTE_MAX)
			tbl_vote[b]++;
		r.spill_valid = 1'b1;
		if (fill == 0) begin
			r.spill_key = it.key;
			r.spill_count = {16'd0, it.weight};
			return r;
		end
		lo = '1;
		lo_idx = 0;
		for (int j = 0; j < fill; j++)
			if (tbl_cnt[base+j] < lo) begin
				lo = tbl_cnt[base+j];
				lo_idx = j;
			end
		q = (lo == 0) ? '1 : {32'd0, tbl_vote[b]} / lo;
		if (q < {48'd0, threshold_q}) begin
			r.spill_key = it.key;
			r.spill_count = {16'd0, it.weight};
		end else begin
			tbl_vote[b] = '0;
			r.spill_key = tbl_key[base+lo_idx];
			r.spill_count = lo[31:0];
			tbl_key[base+lo_idx] = it.key;
			tbl_cnt[base+lo_idx] = {48'd0, it.weight};
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one transaction, predict on acceptance, drop valid afterwards
	task automatic send_item(logic op, logic signed [31:0] key, logic [15:0] weight);
		in_t it;
		it.op = op;
		it.key = key;
		it.weight = weight;
		@(negedge clk);
		repeat (pick_gap()) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		pending_results = {pending_results, filter_step(it)};
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CAPACITY) capacity_q = val[3:0];
		else threshold_q = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		out_stall <= quiet ? 1'b0 : (pick_gap() != 0);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
			$display("FAIL");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %h", $time, out_data);
				failed = 1'b1;
			end else begin
				out_t e;
				e = pending_results.pop_front();
				if (e.spill_valid !== out_data.spill_valid) begin
					$display("%0t spill_valid exp %0d act %0d", $time, e.spill_valid,
						out_data.spill_valid);
					failed = 1'b1;
				end
				if (e.spill_key !== out_data.spill_key) begin
					$display("%0t spill_key exp %h act %h", $time, e.spill_key,
						out_data.spill_key);
					failed = 1'b1;
				end
				if (e.spill_count !== out_data.spill_count) begin
					$display("%0t spill_count exp %h act %h", $time, e.spill_count,
						out_data.spill_count);
					failed = 1'b1;
				end
				if (e.rank_sum !== out_data.rank_sum) begin
					$display("%0t rank_sum exp %h act %h", $time, e.rank_sum,
						out_data.rank_sum);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic test_extremes();
		send_item(OP_RANK, 32'sh8000_0000, 16'h0);
		send_item(OP_INSERT, 32'sh8000_0000, 16'hffff);
		send_item(OP_INSERT, 32'sh7fff_ffff, 16'd1);
		send_item(OP_INSERT, 32'sh0, 16'hffff);
		send_item(OP_INSERT, -32'sd1, 16'h8000);
		send_item(OP_INSERT, 32'sh8000_0000, 16'hffff);
		send_item(OP_RANK, 32'sh8000_0000, 16'hffff);
		send_item(OP_RANK, -32'sd1, 16'h0);
		send_item(OP_RANK, 32'sh7fff_ffff, 16'h1234);
	endtask

	// no free way: misses spill the incoming key, hits still count
	task automatic test_capacity_zero();
		write_reg(CFG_CAPACITY, 16'd0);
		send_item(OP_INSERT, 32'sh0, 16'd3);
		send_item(OP_INSERT, 32'sh1234_5678, 16'd7);
		send_item(OP_INSERT, 32'sh5555_aaaa, 16'd9);
	endtask

	// threshold zero replaces the minimum on every full-bucket miss
	task automatic test_threshold_zero();
		write_reg(CFG_CAPACITY, 16'd1);
		write_reg(CFG_THRESHOLD, 16'd0);
		for (int i = 0; i < 4; i++) send_item(OP_INSERT, hot_keys[i], 16'(i + 1));
	endtask

	// shrink below fill: minimum search covers every filled entry
	task automatic test_shrink();
		write_reg(CFG_CAPACITY, 16'd15);
		write_reg(CFG_THRESHOLD, 16'd1);
		for (int i = 0; i < 6; i++) send_item(OP_INSERT, hot_keys[i], 16'd2);
		write_reg(CFG_CAPACITY, 16'd2);
		for (int i = 6; i < 10; i++) send_item(OP_INSERT, hot_keys[i], 16'd1);
		send_item(OP_RANK, 32'sh7fff_ffff, 16'd0);
	endtask

	task automatic test_random(int n_items);
		logic [15:0] caps[6] = '{16'd1, 16'd8, 16'd3, 16'd15, 16'd0, 16'd5};
		logic [15:0] thrs[6] = '{16'd0, 16'hffff, 16'd1, 16'd2, 16'd4, 16'd0};
		int          per;
		logic [15:0] w;
		logic signed [31:0] k;
		per = n_items / 6;
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_CAPACITY, caps[p]);
			write_reg(CFG_THRESHOLD, (p == 5) ? 16'($urandom_range(0, 65535)) : thrs[p]);
			quiet = (p == 2);
			for (int i = 0; i < per; i++) begin
				k = ($urandom_range(0, 9) == 0) ? 32'($urandom)
					: hot_keys[$urandom_range(0, hot_keys.size() - 1)];
				w = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(1, 6));
				if ($urandom_range(0, 19) == 0)
					send_item(OP_RANK, k, 16'($urandom));
				else
					send_item(OP_INSERT, k, w);
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		logic [31:0] k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CAPACITY;
		cfg_data = '0;
		quiet = 1'b0;
		capacity_q = 4'd8;
		threshold_q = 16'd4;
		for (int i = 0; i < NBKT; i++) begin
			tbl_fill[i] = 0;
			tbl_vote[i] = '0;
		end
		// crowd a few buckets so that evictions happen
		while (hot_keys.size() < 48) begin
			k = $urandom;
			if (bucket_hash(k) < 6) hot_keys = {hot_keys, k};
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_capacity_zero();
		test_threshold_zero();
		test_shrink();
		test_random(1230);

		drain();
		repeat (2000) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
